>>> rtl/core/nps_pkg.sv
// Shared types and constants for the non-preemptive priority scheduler.
// Holds the beat payload structs, the stored process entry and the sequencer states.
// No dependencies.
package nps_pkg;

  localparam int unsigned BurstW = 16;
  localparam int unsigned ArrW   = 16;
  localparam int unsigned PrioW  = 8;
  localparam int unsigned PidxW  = 5;
  localparam int unsigned ClkW   = 22;
  localparam int unsigned SumW   = 27;

  // Input beat: one process description
  typedef struct packed {
    logic [BurstW-1:0] burst;
    logic [ArrW-1:0]   arrival;
    logic [PrioW-1:0]  prio;
    logic              last_proc;
  } in_beat_t;

  // Output beat: one scheduled process
  typedef struct packed {
    logic [PidxW-1:0] proc_index;
    logic [ClkW-1:0]  wait_time;
    logic [ClkW-1:0]  turnaround;
    logic [SumW-1:0]  total_wait;
    logic [SumW-1:0]  total_turnaround;
    logic             last_result;
  } out_beat_t;

  // One stored process
  typedef struct packed {
    logic [BurstW-1:0] burst;
    logic [ArrW-1:0]   arrival;
    logic [PrioW-1:0]  prio;
  } entry_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SCAN_A,
    ST_SCAN_B,
    ST_WTIME,
    ST_TAT,
    ST_SUM,
    ST_OUT
  } sched_state_e;

endpackage

>>> rtl/core/nonpreemptive_priority_scheduler_top.sv
// Non-preemptive priority scheduler, top level.
// Depends on nps_pkg and nps_store.
//
// Usage: send process beats (burst, arrival, prio) on the input channel; they are
// stored in input order, one per cycle while in_ready_o is high. The beat with
// last_proc set closes the set and starts scheduling; in_ready_o then drops until
// the whole schedule has been delivered. Beats beyond MAX_PROCS are dropped, but a
// dropped beat marked last still starts scheduling of the stored set.
// Each result beat names the next process to run with its waiting and turnaround
// time and the running totals; the beat with last_result set closes the schedule.
// Each result needs two passes over the store through its single registered read
// port, then the arithmetic states WTIME, TAT and SUM and the output state OUT.
// The single read port and the serial scan comparator set the cost of a set.
// When the receiver stalls, the result beat is held in the output register and the
// sequencer waits. After the last result is taken the set state clears and the
// block is ready for a new set. Reset clears the count, clock, totals and done
// flags; the store itself is not cleared.
module nonpreemptive_priority_scheduler_top #(
  parameter int unsigned MAX_PROCS = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  nps_pkg::in_beat_t   in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output nps_pkg::out_beat_t  out_data_o
);

  localparam int unsigned IdxW = $clog2(MAX_PROCS);
  localparam int unsigned CntW = $clog2(MAX_PROCS + 1);
  localparam int unsigned ClkW = nps_pkg::ClkW;
  localparam int unsigned SumW = nps_pkg::SumW;

  nps_pkg::sched_state_e state_q, state_d;

  logic [CntW-1:0]          count_q;
  logic [CntW-1:0]          pick_cnt_q;
  logic [CntW-1:0]          scan_addr_q;
  logic                     rd_vld_q;
  logic [IdxW-1:0]          rd_idx_q;
  logic [MAX_PROCS-1:0]     done_q;
  logic [ClkW-1:0]          clock_q;
  logic [SumW-1:0]          wait_sum_q;
  logic [SumW-1:0]          tat_sum_q;
  logic                     any_ready_q;
  logic                     have_pend_q;
  logic                     have_best_q;
  logic                     out_valid_q;

  logic [nps_pkg::ArrW-1:0]   earliest_q;
  logic [nps_pkg::ArrW-1:0]   best_arr_q;
  logic [nps_pkg::BurstW-1:0] best_burst_q;
  logic [nps_pkg::PrioW-1:0]  best_prio_q;
  logic [IdxW-1:0]            best_idx_q;
  logic [ClkW-1:0]            wt_q;
  logic [ClkW-1:0]            tat_q;
  nps_pkg::out_beat_t         out_data_q;

  nps_pkg::entry_t wr_entry;
  nps_pkg::entry_t rd_entry;

  logic            in_acc;
  logic            full;
  logic            scan_more;
  logic            issue;
  logic            pass_end;
  logic            rd_live;
  logic            arr_le;
  logic            better;
  logic            sched_last;
  logic [SumW-1:0] tat_sum_d;
  logic [31:0]     idx_ext;

  assign in_acc    = in_valid_i && in_ready_o;
  assign full      = (count_q == CntW'(MAX_PROCS));
  assign scan_more = (scan_addr_q < count_q);
  assign rd_live   = rd_vld_q && !done_q[rd_idx_q];
  assign arr_le    = (ClkW'(rd_entry.arrival) <= clock_q);
  assign better    = !have_best_q || (rd_entry.prio < best_prio_q) ||
                     ((rd_entry.prio == best_prio_q) && (rd_entry.arrival < best_arr_q));
  assign sched_last = ((pick_cnt_q + CntW'(1)) == count_q);
  assign tat_sum_d  = tat_sum_q + SumW'(tat_q);
  assign idx_ext    = 32'(best_idx_q);

  assign wr_entry.burst   = in_data_i.burst;
  assign wr_entry.arrival = in_data_i.arrival;
  assign wr_entry.prio    = in_data_i.prio;

  // Process store
  nps_store #(
    .Depth (MAX_PROCS),
    .AddrW (IdxW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (in_acc && !full),
    .waddr_i (count_q[IdxW-1:0]),
    .wdata_i (wr_entry),
    .raddr_i (scan_addr_q[IdxW-1:0]),
    .rdata_o (rd_entry)
  );

  // Hold the sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= nps_pkg::ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and handshake
  always_comb begin
    state_d    = state_q;
    issue      = 1'b0;
    pass_end   = 1'b0;
    in_ready_o = 1'b0;
    case (state_q)
      nps_pkg::ST_LOAD: begin
        in_ready_o = 1'b1;
        if (in_valid_i && in_data_i.last_proc) begin
          state_d = nps_pkg::ST_SCAN_A;
        end
      end
      nps_pkg::ST_SCAN_A: begin
        if (scan_more) begin
          issue = 1'b1;
        end else if (!rd_vld_q) begin
          pass_end = 1'b1;
          state_d  = nps_pkg::ST_SCAN_B;
        end
      end
      nps_pkg::ST_SCAN_B: begin
        if (scan_more) begin
          issue = 1'b1;
        end else if (!rd_vld_q) begin
          pass_end = 1'b1;
          state_d  = nps_pkg::ST_WTIME;
        end
      end
      nps_pkg::ST_WTIME: state_d = nps_pkg::ST_TAT;
      nps_pkg::ST_TAT:   state_d = nps_pkg::ST_SUM;
      nps_pkg::ST_SUM:   state_d = nps_pkg::ST_OUT;
      nps_pkg::ST_OUT: begin
        if (out_ready_i) begin
          state_d = out_data_q.last_result ? nps_pkg::ST_LOAD : nps_pkg::ST_SCAN_A;
        end
      end
      default: state_d = nps_pkg::ST_LOAD;
    endcase
  end

  // Control state: counters, clock, totals, flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      pick_cnt_q  <= '0;
      scan_addr_q <= '0;
      rd_vld_q    <= 1'b0;
      done_q      <= '0;
      clock_q     <= '0;
      wait_sum_q  <= '0;
      tat_sum_q   <= '0;
      any_ready_q <= 1'b0;
      have_pend_q <= 1'b0;
      have_best_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      rd_vld_q <= issue;

      // Advance the scan address, rewind at the end of a pass
      if (issue) begin
        scan_addr_q <= scan_addr_q + CntW'(1);
      end else if (pass_end) begin
        scan_addr_q <= '0;
      end

      case (state_q)
        nps_pkg::ST_LOAD: begin
          any_ready_q <= 1'b0;
          have_pend_q <= 1'b0;
          if (in_acc && !full) begin
            count_q <= count_q + CntW'(1);
          end
        end
        nps_pkg::ST_SCAN_A: begin
          have_best_q <= 1'b0;
          if (rd_live) begin
            if (arr_le) begin
              any_ready_q <= 1'b1;
            end
            have_pend_q <= 1'b1;
          end
          // Jump the clock to the earliest arrival when nothing is ready
          if (pass_end && !any_ready_q && have_pend_q) begin
            clock_q <= ClkW'(earliest_q);
          end
        end
        nps_pkg::ST_SCAN_B: begin
          if (rd_live && arr_le && better) begin
            have_best_q <= 1'b1;
          end
        end
        nps_pkg::ST_WTIME: begin
          clock_q             <= clock_q + ClkW'(best_burst_q);
          done_q[best_idx_q]  <= 1'b1;
        end
        nps_pkg::ST_TAT: begin
          wait_sum_q <= wait_sum_q + SumW'(wt_q);
        end
        nps_pkg::ST_SUM: begin
          tat_sum_q   <= tat_sum_d;
          out_valid_q <= 1'b1;
        end
        nps_pkg::ST_OUT: begin
          any_ready_q <= 1'b0;
          have_pend_q <= 1'b0;
          if (out_ready_i) begin
            out_valid_q <= 1'b0;
            // Drop the finished set
            if (out_data_q.last_result) begin
              count_q    <= '0;
              pick_cnt_q <= '0;
              done_q     <= '0;
              clock_q    <= '0;
              wait_sum_q <= '0;
              tat_sum_q  <= '0;
            end else begin
              pick_cnt_q <= pick_cnt_q + CntW'(1);
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Payload: scan candidates, times and the output beat
  always_ff @(posedge clk_i) begin
    rd_idx_q <= scan_addr_q[IdxW-1:0];
    case (state_q)
      nps_pkg::ST_SCAN_A: begin
        if (rd_live && (!have_pend_q || (rd_entry.arrival < earliest_q))) begin
          earliest_q <= rd_entry.arrival;
        end
      end
      nps_pkg::ST_SCAN_B: begin
        if (rd_live && arr_le && better) begin
          best_arr_q   <= rd_entry.arrival;
          best_burst_q <= rd_entry.burst;
          best_prio_q  <= rd_entry.prio;
          best_idx_q   <= rd_idx_q;
        end
      end
      nps_pkg::ST_WTIME: begin
        wt_q <= clock_q - ClkW'(best_arr_q);
      end
      nps_pkg::ST_TAT: begin
        tat_q <= wt_q + ClkW'(best_burst_q);
      end
      nps_pkg::ST_SUM: begin
        out_data_q.proc_index       <= idx_ext[nps_pkg::PidxW-1:0];
        out_data_q.wait_time        <= wt_q;
        out_data_q.turnaround       <= tat_q;
        out_data_q.total_wait       <= wait_sum_q;
        out_data_q.total_turnaround <= tat_sum_d;
        out_data_q.last_result      <= sched_last;
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

>>> rtl/core/nps_store.sv
// Process store: one write port and one registered read port.
// Depends on nps_pkg for the entry type.
module nps_store #(
  parameter int unsigned Depth = 32,
  parameter int unsigned AddrW = 5
) (
  input  logic            clk_i,
  input  logic            we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  nps_pkg::entry_t wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output nps_pkg::entry_t rdata_o
);

  nps_pkg::entry_t mem_q [Depth];
  nps_pkg::entry_t rdata_q;

  // Write one entry per cycle when we_i is set
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Register the read data
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/nps_checker.sv
// Port-level checks for the non-preemptive priority scheduler top level.
// Depends on nps_pkg; bound to nonpreemptive_priority_scheduler_top below.
module nps_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input nps_pkg::in_beat_t  in_data_i,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input nps_pkg::out_beat_t out_data_o
);

  // Never take a process beat while a result beat is pending
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input ready while a result is pending");

  // Close loading once the last process beat is taken
  a_last_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && in_data_i.last_proc) |=> !in_ready_o)
    else $error("still loading after the last process beat");

  // Reopen loading right after the final result beat
  a_final_reopens: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && out_data_o.last_result) |=> in_ready_o)
    else $error("not ready for a new set after the final result");

  // Hold a stalled result beat
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("stalled result beat changed");

endmodule

bind nonpreemptive_priority_scheduler_top nps_checker u_nps_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

>>> bench/nonpreemptive_priority_scheduler_top_tb.sv
// Self-checking testbench for the non-preemptive priority scheduler top level.
// Drives process beats, predicts each schedule in-house and checks every result beat.
// Depends on nps_pkg and nonpreemptive_priority_scheduler_top.
module nonpreemptive_priority_scheduler_top_tb;

  localparam int unsigned MaxProcs    = 32;
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned DrainCycles = 50;
  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned RandomBeats = 85;

  localparam int unsigned BurstW = nps_pkg::BurstW;
  localparam int unsigned ArrW   = nps_pkg::ArrW;
  localparam int unsigned PrioW  = nps_pkg::PrioW;
  localparam int unsigned PidxW  = nps_pkg::PidxW;
  localparam int unsigned ClkW   = nps_pkg::ClkW;
  localparam int unsigned SumW   = nps_pkg::SumW;

  // One row of the directed table; want is used only where has_want is set
  typedef struct packed {
    nps_pkg::in_beat_t  beat;
    logic               has_want;
    nps_pkg::out_beat_t want;
  } dir_row_t;

  localparam nps_pkg::out_beat_t NoWant = '0;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  nps_pkg::in_beat_t  in_data_i;
  logic               out_valid_o;
  logic               out_ready_i;
  nps_pkg::out_beat_t out_data_o;

  // Sideband that travels with the offered beat
  logic               row_has_want;
  nps_pkg::out_beat_t row_want;

  logic      hold_req;
  int        idle_pct = 38;
  int        mismatches = 0;
  int        cycles = 0;

  // Predictor state: stored processes and the running schedule
  logic [BurstW-1:0] st_burst [MaxProcs];
  logic [ArrW-1:0]   st_arr   [MaxProcs];
  logic [PrioW-1:0]  st_prio  [MaxProcs];
  bit                ran      [MaxProcs];
  int unsigned       stored = 0;
  logic [ClkW-1:0]   now = '0;
  logic [SumW-1:0]   wait_acc = '0;
  logic [SumW-1:0]   tat_acc = '0;

  nps_pkg::out_beat_t fresh_runs [$];
  nps_pkg::out_beat_t pending_runs [$];

  dir_row_t dir_rows [13];

  nonpreemptive_priority_scheduler_top #(
    .MAX_PROCS(MaxProcs)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Store one process; on the closing beat, run the whole set and clear it
  function automatic void load_process(input nps_pkg::in_beat_t b);
    int unsigned n, k, i, pick;
    logic any_ready, have_pend, have_pick;
    logic [ArrW-1:0] earliest;
    logic [ClkW-1:0] wt, tat;
    nps_pkg::out_beat_t r;
    fresh_runs.delete();
    if (stored < MaxProcs) begin
      st_burst[stored] = b.burst;
      st_arr[stored]   = b.arrival;
      st_prio[stored]  = b.prio;
      ran[stored]      = 1'b0;
      stored++;
    end
    if (!b.last_proc) return;
    n = stored;
    for (k = 0; k < n; k++) begin
      any_ready = 1'b0;
      have_pend = 1'b0;
      earliest  = '0;
      for (i = 0; i < n; i++) begin
        if (!ran[i]) begin
          if (ClkW'(st_arr[i]) <= now) any_ready = 1'b1;
          if (!have_pend || st_arr[i] < earliest) begin
            earliest  = st_arr[i];
            have_pend = 1'b1;
          end
        end
      end
      // Nothing has arrived: jump the clock to the earliest pending arrival
      if (!any_ready && have_pend) now = ClkW'(earliest);
      have_pick = 1'b0;
      pick = 0;
      for (i = 0; i < n; i++) begin
        if (!ran[i] && ClkW'(st_arr[i]) <= now) begin
          if (!have_pick || st_prio[i] < st_prio[pick] ||
              (st_prio[i] == st_prio[pick] && st_arr[i] < st_arr[pick])) begin
            pick = i;
            have_pick = 1'b1;
          end
        end
      end
      wt  = now - ClkW'(st_arr[pick]);
      tat = wt + ClkW'(st_burst[pick]);
      ran[pick] = 1'b1;
      now       = now + ClkW'(st_burst[pick]);
      wait_acc  = wait_acc + SumW'(wt);
      tat_acc   = tat_acc + SumW'(tat);
      r.proc_index       = PidxW'(pick);
      r.wait_time        = wt;
      r.turnaround       = tat;
      r.total_wait       = wait_acc;
      r.total_turnaround = tat_acc;
      r.last_result      = (k == n - 1);
      fresh_runs.push_back(r);
    end
    stored   = 0;
    now      = '0;
    wait_acc = '0;
    tat_acc  = '0;
    for (i = 0; i < MaxProcs; i++) ran[i] = 1'b0;
  endfunction

  task automatic note_mismatch(input string what, input longint unsigned got,
                               input longint unsigned want);
    mismatches++;
    $display("mismatch on %s: got %0d, want %0d", what, got, want);
  endtask

  // Offer one beat after a random gap, hold it until accepted
  task automatic offer(input nps_pkg::in_beat_t b, input logic has_want,
                       input nps_pkg::out_beat_t want);
    int gap;
    gap = 0;
    while ($urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    in_data_i    <= b;
    row_has_want <= has_want;
    row_want     <= want;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Predict on every accepted input beat, check every accepted result beat
  always @(posedge clk_i) begin : beat_check
    nps_pkg::out_beat_t got, want;
    if (rst_ni && in_valid_i && in_ready_o) begin
      load_process(in_data_i);
      if (row_has_want) pending_runs.push_back(row_want);
      else foreach (fresh_runs[j]) pending_runs.push_back(fresh_runs[j]);
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = out_data_o;
      if (pending_runs.size() == 0) begin
        note_mismatch("result beat with nothing expected, proc_index", got.proc_index, 0);
      end else begin
        want = pending_runs.pop_front();
        if (got.proc_index != want.proc_index)
          note_mismatch("proc_index", got.proc_index, want.proc_index);
        if (got.wait_time != want.wait_time)
          note_mismatch("wait_time", got.wait_time, want.wait_time);
        if (got.turnaround != want.turnaround)
          note_mismatch("turnaround", got.turnaround, want.turnaround);
        if (got.total_wait != want.total_wait)
          note_mismatch("total_wait", got.total_wait, want.total_wait);
        if (got.total_turnaround != want.total_turnaround)
          note_mismatch("total_turnaround", got.total_turnaround, want.total_turnaround);
        if (got.last_result != want.last_result)
          note_mismatch("last_result", got.last_result, want.last_result);
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off on request
  initial begin : receiver
    bit hold_taken;
    hold_taken = 1'b0;
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        out_ready_i <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end
      out_ready_i <= ($urandom_range(99) >= idle_pct);
    end
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin : stimulus
    nps_pkg::in_beat_t b;
    int unsigned       n, i, sent, set_no, kind, arr_mode, pick_burst;
    bit                wide_prio;

    rst_ni       <= 1'b0;
    in_valid_i   <= 1'b0;
    in_data_i    <= '0;
    row_has_want <= 1'b0;
    row_want     <= NoWant;
    hold_req     <= 1'b0;

    // Single all-ones process right after reset: clock jumps to its arrival
    dir_rows[0]  = '{'{16'hFFFF, 16'hFFFF, 8'hFF, 1'b1}, 1'b1,
                     '{5'd0, 22'd0, 22'd65535, 27'd0, 27'd65535, 1'b1}};
    // Single zero-burst process at time zero
    dir_rows[1]  = '{'{16'h0000, 16'h0000, 8'h00, 1'b1}, 1'b1,
                     '{5'd0, 22'd0, 22'd0, 27'd0, 27'd0, 1'b1}};
    // Priority and arrival ties, broken by arrival then input order
    dir_rows[2]  = '{'{16'd5, 16'd0, 8'd3, 1'b0}, 1'b0, NoWant};
    dir_rows[3]  = '{'{16'd2, 16'd0, 8'd1, 1'b0}, 1'b0, NoWant};
    dir_rows[4]  = '{'{16'd4, 16'd1, 8'd1, 1'b0}, 1'b0, NoWant};
    dir_rows[5]  = '{'{16'd3, 16'd0, 8'd1, 1'b1}, 1'b0, NoWant};
    // Idle gap between arrivals
    dir_rows[6]  = '{'{16'd2, 16'd10, 8'd5, 1'b0}, 1'b0, NoWant};
    dir_rows[7]  = '{'{16'd3, 16'd100, 8'd0, 1'b1}, 1'b0, NoWant};
    // Field extremes in one set
    dir_rows[8]  = '{'{16'hFFFF, 16'h0000, 8'hFF, 1'b0}, 1'b0, NoWant};
    dir_rows[9]  = '{'{16'hFFFF, 16'hFFFF, 8'h00, 1'b0}, 1'b0, NoWant};
    dir_rows[10] = '{'{16'd1, 16'd1, 8'h80, 1'b1}, 1'b0, NoWant};
    // Alternating bit patterns
    dir_rows[11] = '{'{16'hAAAA, 16'h5555, 8'hAA, 1'b0}, 1'b0, NoWant};
    dir_rows[12] = '{'{16'h5555, 16'hAAAA, 8'h55, 1'b1}, 1'b0, NoWant};

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[r]) offer(dir_rows[r].beat, dir_rows[r].has_want, dir_rows[r].want);

    // Random sets: the long hold-off begins with set 1, on set 0's results; set 2 overfills
    // the store; sets 4 to 6 load with no gaps, and results of sets 3 to 5 see no stalls
    sent = 0;
    for (set_no = 0; sent < RandomBeats; set_no++) begin
      kind = $urandom_range(99);
      if (set_no == 2 || kind < 4) n = $urandom_range(MaxProcs + 3, MaxProcs + 1);
      else if (kind < 20)          n = $urandom_range(MaxProcs, 9);
      else                         n = $urandom_range(8, 1);
      idle_pct = (set_no >= 4 && set_no <= 6) ? 0 : 38;
      if (set_no == 1) hold_req <= 1'b1;
      arr_mode  = $urandom_range(3);
      wide_prio = $urandom_range(1);
      for (i = 0; i < n; i++) begin
        pick_burst = $urandom_range(99);
        if (pick_burst < 8)       b.burst = '0;
        else if (pick_burst < 20) b.burst = BurstW'($urandom);
        else                      b.burst = BurstW'($urandom_range(30, 1));
        case (arr_mode)
          0:       b.arrival = ArrW'($urandom_range(20));
          1:       b.arrival = ArrW'($urandom_range(2000));
          2:       b.arrival = ArrW'($urandom);
          default: b.arrival = ArrW'(1000 + $urandom_range(50));
        endcase
        b.prio      = wide_prio ? PrioW'($urandom) : PrioW'($urandom_range(3));
        b.last_proc = (i == n - 1);
        offer(b, 1'b0, NoWant);
      end
      sent += n;
    end
    in_valid_i <= 1'b0;
    idle_pct = 38;

    // Drain outstanding results, then let the block settle
    do @(posedge clk_i); while (pending_runs.size() != 0);
    repeat (DrainCycles) @(posedge clk_i);
    if (pending_runs.size() != 0)
      note_mismatch("results never delivered", 0, pending_runs.size());

    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/core/nps_pkg.sv
rtl/core/nps_store.sv
rtl/core/nonpreemptive_priority_scheduler_top.sv
rtl/core/nps_checker.sv
bench/nonpreemptive_priority_scheduler_top_tb.sv
